// ----- sv/fbtr_pkg.sv -----
// Shared types, codes and constants of the frame buffer text renderer
package fbtr_pkg;

   // glyph cell size in pixels (square)
   localparam int FONT_SIZE = 8;

   // column offset register
   localparam int              OFFSET_W     = 4;
   localparam logic [3:0]      OFFSET_RESET = 4'd3;

   // cursor after reset
   localparam logic [7:0]      CURSOR_X_RESET = 8'd3;

   // function codes
   localparam logic [2:0]      FUNC_FILL       = 3'd0;
   localparam logic [2:0]      FUNC_PIXEL      = 3'd1;
   localparam logic [2:0]      FUNC_WRITE_CHAR = 3'd2;
   localparam logic [2:0]      FUNC_SET_CURSOR = 3'd3;
   localparam logic [2:0]      FUNC_LOAD_FONT  = 3'd4;
   localparam logic [2:0]      FUNC_READ_BYTE  = 3'd5;

   // status codes
   localparam logic            STATUS_DONE     = 1'b0;
   localparam logic            STATUS_REJECTED = 1'b1;

   // fill bytes
   localparam logic [7:0]      FILL_WHITE = 8'hFF;
   localparam logic [7:0]      FILL_BLACK = 8'h00;

   // character map
   localparam logic [7:0]      CHAR_SPACE  = 8'd32;
   localparam logic [7:0]      DIGIT_FIRST = 8'd46;
   localparam logic [7:0]      DIGIT_LAST  = 8'd57;
   localparam logic [7:0]      DIGIT_BASE  = 8'd45;
   localparam logic [7:0]      ALPHA_FIRST = 8'd65;
   localparam logic [7:0]      ALPHA_LAST  = 8'd90;
   localparam logic [7:0]      ALPHA_BASE  = 8'd52;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic       colour;
      logic [7:0] char_code;
      logic [5:0] glyph_slot;
      logic [2:0] glyph_row;
      logic [7:0] glyph_bits;
      logic [9:0] byte_addr;
   } fbtr_req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] read_data;
   } fbtr_rsp_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] slot;
   } fbtr_glyph_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_READ,
      ST_GLYPH,
      ST_DRAW,
      ST_RESULT
   } fbtr_state_type;

   // Map a character code to its glyph slot
   function automatic fbtr_glyph_type fbtr_glyph_of(input logic [7:0] code);
      fbtr_glyph_type g;
      logic [7:0]     diff;
      g.hit  = 1'b1;
      g.slot = '0;
      diff   = '0;
      if (code >= DIGIT_FIRST && code <= DIGIT_LAST) begin
         diff   = code - DIGIT_BASE;
         g.slot = diff[5:0];
      end else if (code >= ALPHA_FIRST && code <= ALPHA_LAST) begin
         diff   = code - ALPHA_BASE;
         g.slot = diff[5:0];
      end else if (code != CHAR_SPACE) begin
         g.hit = 1'b0;
      end
      return g;
   endfunction

endpackage

// ----- sv/framebuffer_text_renderer_top.sv -----
// Top level of the page frame buffer text renderer
//
// Channel  Dir  Handshake               Payload
// req      in   req_valid / req_stall   req_data (fbtr_req_type)
// rsp      out  rsp_valid / rsp_stall   rsp_data (fbtr_rsp_type)
// csr      in   csr_valid / csr_ready   csr_data (column offset, 4 bits)
//
// Pixel, set cursor, font load and rejected beats go from idle straight to the result state;
// a byte read passes ST_READ first. A rendered character first reads the eight glyph rows,
// then streams 16 frame buffer read-modify-writes one a cycle (8 columns, up to 2 pages each).
// A fill writes one byte a cycle through the frame buffer write port.
// After reset a clearing pass zeroes all FB_BYTES bytes (1024 at default size) of the
// buffer while req is stalled; csr writes are taken. A result held by rsp_stall
// waits in the output register while the next req beat is taken.
module framebuffer_text_renderer_top #(
   parameter int DISPLAY_WIDTH  = 128,
   parameter int DISPLAY_HEIGHT = 64,
   parameter int GLYPH_SLOTS    = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fbtr_pkg::fbtr_req_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fbtr_pkg::fbtr_rsp_type         rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fbtr_pkg::OFFSET_W-1:0]  csr_data
);
   import fbtr_pkg::*;

   localparam int FB_PAGES      = (DISPLAY_HEIGHT + 7) / 8;
   localparam int FB_BYTES      = DISPLAY_WIDTH * FB_PAGES;
   localparam int FB_AW         = $clog2(FB_BYTES);
   localparam int GLYPH_ENTRIES = GLYPH_SLOTS * FONT_SIZE;
   localparam int GLYPH_AW      = $clog2(GLYPH_ENTRIES);
   localparam logic [FB_AW-1:0] SWEEP_LAST = FB_AW'(FB_BYTES - 1);

   // control and state registers
   fbtr_state_type      state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [7:0]          cursor_x_ff, cursor_x_in;
   logic [7:0]          cursor_y_ff, cursor_y_in;
   logic [3:0]          text_line_ff, text_line_in;
   logic [3:0]          step_ff, step_in;
   logic [FB_AW-1:0]    sweep_ff, sweep_in;
   logic                st_en_ff, st_en_in;

   // payload registers
   fbtr_rsp_type        rsp_data_ff, rsp_data_in;
   fbtr_rsp_type        res_ff, res_in;
   logic                white_ff, white_in;
   logic [5:0]          slot_ff, slot_in;
   logic [7:0]          fill_ff, fill_in;
   logic [7:0]          glyph_rows_ff [FONT_SIZE];
   logic [7:0]          glyph_rows_in [FONT_SIZE];
   logic [FB_AW-1:0]    st_addr_ff, st_addr_in;
   logic [7:0]          st_mask_ff, st_mask_in;
   logic [7:0]          st_data_ff, st_data_in;

   // memory ports
   logic                fb_we;
   logic [FB_AW-1:0]    fb_waddr, fb_raddr;
   logic [7:0]          fb_wdata, fb_rdata;
   logic                glyph_we;
   logic [GLYPH_AW-1:0] glyph_waddr, glyph_raddr;
   logic [7:0]          glyph_rdata;

   logic                accept;
   logic                rsp_free;

   // wrap rules and character map
   logic [7:0]          wrap_x, wrap_y;
   logic [3:0]          wrap_line;
   fbtr_glyph_type      glyph_hit;
   logic                glyph_ok;

   // single pixel access
   logic [FB_AW-1:0]    pix_addr;
   logic [7:0]          pix_mask;
   logic                pix_ok;

   // character column access
   logic [2:0]          acc_col;
   logic                acc_hi;
   logic [8:0]          acc_x;
   logic [5:0]          acc_page;
   logic [7:0]          acc_bits;
   logic [15:0]         acc_bits_wide, acc_mask_wide;
   logic [7:0]          acc_ymask, acc_mask, acc_data;
   logic                acc_en;
   logic [FB_AW-1:0]    acc_addr;
   logic [3:0]          step_prev;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // apply line wrap, then page wrap
   always_comb begin
      wrap_x    = cursor_x_ff;
      wrap_y    = cursor_y_ff;
      wrap_line = text_line_ff;
      if (cursor_x_ff > DISPLAY_WIDTH) begin
         wrap_line = text_line_ff + 4'd1;
         wrap_x    = {4'd0, offset_ff};
         wrap_y    = {1'b0, wrap_line, 3'd0};
      end
      if (wrap_y > DISPLAY_HEIGHT) begin
         wrap_x    = {4'd0, offset_ff};
         wrap_y    = 8'd0;
         wrap_line = 4'd0;
      end
   end

   assign glyph_hit = fbtr_glyph_of(req_data.char_code);
   assign glyph_ok  = glyph_hit.hit && (glyph_hit.slot < GLYPH_SLOTS);

   // locate the byte and bit of a single pixel
   assign pix_ok   = (req_data.pos_x < DISPLAY_WIDTH) && (req_data.pos_y < DISPLAY_HEIGHT);
   assign pix_addr = FB_AW'(req_data.pos_x)
                   + FB_AW'(req_data.pos_y[7:3]) * FB_AW'(DISPLAY_WIDTH);
   assign pix_mask = 8'd1 << req_data.pos_y[2:0];

   // build one column byte of the glyph and place it on its page
   assign acc_col   = step_ff[3:1];
   assign acc_hi    = step_ff[0];
   assign acc_x     = {1'b0, cursor_x_ff} + {6'd0, acc_col};
   assign acc_page  = {1'b0, cursor_y_ff[7:3]} + {5'd0, acc_hi};
   assign step_prev = step_ff - 4'd1;

   always_comb begin
      for (int i = 0; i < FONT_SIZE; i++) begin
         acc_bits[i]  = ~(glyph_rows_ff[i][3'd7 - acc_col] ^ white_ff);
         acc_ymask[i] = ({acc_page, 3'(i)} < DISPLAY_HEIGHT);
      end
   end

   assign acc_bits_wide = {8'd0, acc_bits} << cursor_y_ff[2:0];
   assign acc_mask_wide = 16'h00FF << cursor_y_ff[2:0];
   assign acc_data      = acc_hi ? acc_bits_wide[15:8] : acc_bits_wide[7:0];
   assign acc_mask      = (acc_hi ? acc_mask_wide[15:8] : acc_mask_wide[7:0]) & acc_ymask;
   assign acc_en        = (acc_x < DISPLAY_WIDTH) && (acc_mask != 8'd0);
   assign acc_addr      = FB_AW'(acc_x) + FB_AW'(acc_page) * FB_AW'(DISPLAY_WIDTH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sweep_ff == SWEEP_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.func)
                  FUNC_FILL:       state_in = ST_FILL;
                  FUNC_WRITE_CHAR: state_in = glyph_ok ? ST_GLYPH : ST_RESULT;
                  FUNC_READ_BYTE:  state_in = (req_data.byte_addr < FB_BYTES) ? ST_READ
                                                                              : ST_RESULT;
                  default:         state_in = ST_RESULT;
               endcase
            end
         end
         ST_FILL: begin
            if (sweep_ff == SWEEP_LAST) state_in = ST_RESULT;
         end
         ST_READ: begin
            state_in = ST_RESULT;
         end
         ST_GLYPH: begin
            if (step_ff == 4'd8) state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (step_ff == 4'd15) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      res_in        = res_ff;
      offset_in     = offset_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      text_line_in  = text_line_ff;
      step_in       = step_ff;
      sweep_in      = sweep_ff;
      white_in      = white_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      glyph_rows_in = glyph_rows_ff;
      st_en_in      = 1'b0;
      st_addr_in    = st_addr_ff;
      st_mask_in    = st_mask_ff;
      st_data_in    = st_data_ff;
      fb_raddr      = acc_addr;
      glyph_we      = 1'b0;

      // take a register write
      if (csr_valid && csr_ready) offset_in = csr_data;

      case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + FB_AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               res_in.status    = STATUS_DONE;
               res_in.read_data = 8'd0;
               case (req_data.func)
                  FUNC_FILL: begin
                     fill_in  = req_data.colour ? FILL_WHITE : FILL_BLACK;
                     sweep_in = '0;
                  end
                  FUNC_PIXEL: begin
                     if (pix_ok) begin
                        st_en_in   = 1'b1;
                        st_addr_in = pix_addr;
                        st_mask_in = pix_mask;
                        st_data_in = req_data.colour ? pix_mask : 8'd0;
                        fb_raddr   = pix_addr;
                     end else begin
                        res_in.status = STATUS_REJECTED;
                     end
                  end
                  FUNC_WRITE_CHAR: begin
                     cursor_x_in  = wrap_x;
                     cursor_y_in  = wrap_y;
                     text_line_in = wrap_line;
                     if (glyph_ok) begin
                        slot_in  = glyph_hit.slot;
                        white_in = req_data.colour;
                        step_in  = 4'd0;
                     end else begin
                        res_in.status = STATUS_REJECTED;
                     end
                  end
                  FUNC_SET_CURSOR: begin
                     if (req_data.pos_x > DISPLAY_WIDTH || req_data.pos_y > DISPLAY_HEIGHT) begin
                        res_in.status = STATUS_REJECTED;
                     end else begin
                        cursor_x_in = req_data.pos_x + {4'd0, offset_ff};
                        cursor_y_in = req_data.pos_y;
                     end
                  end
                  FUNC_LOAD_FONT: begin
                     if (req_data.glyph_slot < GLYPH_SLOTS) begin
                        glyph_we = 1'b1;
                     end else begin
                        res_in.status = STATUS_REJECTED;
                     end
                  end
                  FUNC_READ_BYTE: begin
                     if (req_data.byte_addr < FB_BYTES) begin
                        fb_raddr = FB_AW'(req_data.byte_addr);
                     end else begin
                        res_in.status = STATUS_REJECTED;
                     end
                  end
                  default: begin
                     res_in.status = STATUS_REJECTED;
                  end
               endcase
            end
         end
         ST_FILL: begin
            sweep_in = sweep_ff + FB_AW'(1);
         end
         ST_READ: begin
            res_in.read_data = fb_rdata;
         end
         ST_GLYPH: begin
            // capture the row requested in the previous cycle
            if (step_ff != 4'd0) glyph_rows_in[step_prev[2:0]] = glyph_rdata;
            step_in = (step_ff == 4'd8) ? 4'd0 : step_ff + 4'd1;
         end
         ST_DRAW: begin
            // issue the read, merge and write it back next cycle
            st_en_in   = acc_en;
            st_addr_in = acc_addr;
            st_mask_in = acc_mask;
            st_data_in = acc_data;
            step_in    = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               cursor_x_in = cursor_x_ff + 8'(FONT_SIZE);
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
            st_en_in = 1'b0;
         end
      endcase
   end

   // frame buffer write port: sweep or merged read-modify-write
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         fb_we    = 1'b1;
         fb_waddr = sweep_ff;
         fb_wdata = FILL_BLACK;
      end else if (state_ff == ST_FILL) begin
         fb_we    = 1'b1;
         fb_waddr = sweep_ff;
         fb_wdata = fill_ff;
      end else begin
         fb_we    = st_en_ff;
         fb_waddr = st_addr_ff;
         fb_wdata = (fb_rdata & ~st_mask_ff) | (st_data_ff & st_mask_ff);
      end
   end

   assign glyph_waddr = GLYPH_AW'({req_data.glyph_slot, req_data.glyph_row});
   assign glyph_raddr = GLYPH_AW'({slot_ff, step_ff[2:0]});

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= OFFSET_RESET;
         cursor_x_ff  <= CURSOR_X_RESET;
         cursor_y_ff  <= 8'd0;
         text_line_ff <= 4'd0;
         step_ff      <= 4'd0;
         sweep_ff     <= '0;
         st_en_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         offset_ff    <= offset_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         text_line_ff <= text_line_in;
         step_ff      <= step_in;
         sweep_ff     <= sweep_in;
         st_en_ff     <= st_en_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      res_ff        <= res_in;
      white_ff      <= white_in;
      slot_ff       <= slot_in;
      fill_ff       <= fill_in;
      glyph_rows_ff <= glyph_rows_in;
      st_addr_ff    <= st_addr_in;
      st_mask_ff    <= st_mask_in;
      st_data_ff    <= st_data_in;
   end

   fbtr_ram #(
      .WIDTH (8),
      .DEPTH (FB_BYTES)
   ) u_frame_buffer (
      .clock   (clock),
      .wr_en   (fb_we),
      .wr_addr (fb_waddr),
      .wr_data (fb_wdata),
      .rd_addr (fb_raddr),
      .rd_data (fb_rdata)
   );

   fbtr_ram #(
      .WIDTH (8),
      .DEPTH (GLYPH_ENTRIES)
   ) u_glyph_store (
      .clock   (clock),
      .wr_en   (glyph_we),
      .wr_addr (glyph_waddr),
      .wr_data (req_data.glyph_bits),
      .rd_addr (glyph_raddr),
      .rd_data (glyph_rdata)
   );

endmodule

// ----- sv/fbtr_ram.sv -----
// Generic simple dual port RAM with registered read
module fbtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, read one word through the rd_data_ff register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/fbtr_checker.sv -----
// Port checker for the frame buffer text renderer and its bind
module fbtr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input fbtr_pkg::fbtr_req_type         req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input fbtr_pkg::fbtr_rsp_type         rsp_data,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [fbtr_pkg::OFFSET_W-1:0]  csr_data
);
   import fbtr_pkg::*;

   logic       req_beat, rsp_beat;
   logic [1:0] pending_ff, pending_in;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // count beats taken but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) pending_in = pending_ff + 2'd1;
      if (!req_beat && rsp_beat) pending_in = pending_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");

   // one beat at a time: stall right after a taken beat
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("request taken while previous beat in work");

   // no result without a request, at most one waiting plus one in work
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> pending_ff != 2'd2 && pending_ff != 2'd3)
      else $error("too many requests outstanding");

   // clearing pass blocks requests after reset, without a side effect on csr
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall && csr_ready && !rsp_valid)
      else $error("request accepted during clearing pass");

endmodule

bind framebuffer_text_renderer_top fbtr_checker u_fbtr_checker (.*);

// ----- tb/framebuffer_text_renderer_top_tb.sv -----
// Self-checking testbench for the page frame buffer text renderer
`timescale 1ns / 100ps

module framebuffer_text_renderer_top_tb;
   import fbtr_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 3;
   localparam int DISP_W         = 128;
   localparam int DISP_H         = 64;
   localparam int SLOTS          = 64;
   localparam int FB_BYTES       = DISP_W * ((DISP_H + 7) / 8);
   localparam int PHASES         = 5;
   localparam int PHASE_ITEMS    = 205;
   localparam int TAIL_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int REPORT_LIMIT   = 10;

   // function codes the block does not implement
   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;

   typedef struct packed {
      fbtr_req_type cmd;
      logic         typed;
      fbtr_rsp_type want;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   fbtr_req_type        req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   fbtr_rsp_type        rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [OFFSET_W-1:0] csr_data;

   // shadow copy of the block state
   logic [7:0]          shadow_fb [FB_BYTES];
   logic [7:0]          shadow_font [SLOTS * FONT_SIZE];
   logic [7:0]          rows_loaded [SLOTS];
   logic [7:0]          cur_x;
   logic [7:0]          cur_y;
   logic [3:0]          text_row;
   logic [3:0]          col_offset;

   fbtr_rsp_type        pending_rsp_q [$];
   dir_row_type         dir_rows [$];

   logic                req_eager = 1'b0;
   logic                rsp_eager = 1'b0;
   int                  quiet_cycles = 0;
   int                  mismatches = 0;
   int                  cmds_sent = 0;
   int                  rejects = 0;
   int                  results_checked = 0;
   int                  chars_drawn = 0;
   int                  line_wraps = 0;
   int                  page_wraps = 0;
   int                  offset_writes = 0;

   // Set one pixel of the shadow buffer, clipping off-display pixels
   function automatic void plot(input int x, input int y, input logic white);
      if (x >= DISP_W || y >= DISP_H)
         return;
      shadow_fb[x + (y / 8) * DISP_W][y % 8] = white;
   endfunction

   // Map a character to its glyph slot; return 0 for unsupported codes
   function automatic logic map_glyph(input logic [7:0] code, output logic [5:0] slot);
      slot = '0;
      if (code >= DIGIT_FIRST && code <= DIGIT_LAST) begin
         slot = 6'(code - DIGIT_BASE);
         return 1'b1;
      end
      if (code >= ALPHA_FIRST && code <= ALPHA_LAST) begin
         slot = 6'(code - ALPHA_BASE);
         return 1'b1;
      end
      return code == CHAR_SPACE;
   endfunction

   // Apply wrap rules, draw one glyph cell at the cursor and advance it
   function automatic logic draw_char(input logic [7:0] code, input logic white);
      logic [5:0] slot;
      logic [7:0] bits;
      int         i;
      int         j;
      if (cur_x > DISP_W) begin
         text_row = text_row + 4'd1;
         cur_x    = 8'(col_offset);
         cur_y    = 8'(FONT_SIZE * text_row);
         line_wraps++;
      end
      if (cur_y > DISP_H) begin
         cur_x    = 8'(col_offset);
         cur_y    = 8'd0;
         text_row = 4'd0;
         page_wraps++;
      end
      if (!map_glyph(code, slot))
         return STATUS_REJECTED;
      for (i = 0; i < FONT_SIZE; i++) begin
         bits = shadow_font[slot * FONT_SIZE + i];
         for (j = 0; j < FONT_SIZE; j++)
            plot(cur_x + j, cur_y + i, bits[7 - j] ? white : !white);
      end
      cur_x = cur_x + 8'(FONT_SIZE);
      chars_drawn++;
      return STATUS_DONE;
   endfunction

   // Run one command on the shadow state and return the response it gives
   function automatic fbtr_rsp_type apply_cmd(input fbtr_req_type c);
      fbtr_rsp_type r;
      r.status    = STATUS_DONE;
      r.read_data = 8'h00;
      case (c.func)
         FUNC_FILL: begin
            foreach (shadow_fb[i])
               shadow_fb[i] = c.colour ? FILL_WHITE : FILL_BLACK;
         end
         FUNC_PIXEL: begin
            if (c.pos_x >= DISP_W || c.pos_y >= DISP_H)
               r.status = STATUS_REJECTED;
            else
               plot(c.pos_x, c.pos_y, c.colour);
         end
         FUNC_WRITE_CHAR: begin
            r.status = draw_char(c.char_code, c.colour);
         end
         FUNC_SET_CURSOR: begin
            if (c.pos_x > DISP_W || c.pos_y > DISP_H) begin
               r.status = STATUS_REJECTED;
            end else begin
               cur_x = c.pos_x + 8'(col_offset);
               cur_y = c.pos_y;
            end
         end
         FUNC_LOAD_FONT: begin
            if (c.glyph_slot >= SLOTS) begin
               r.status = STATUS_REJECTED;
            end else begin
               shadow_font[c.glyph_slot * FONT_SIZE + c.glyph_row] = c.glyph_bits;
               rows_loaded[c.glyph_slot][c.glyph_row]               = 1'b1;
            end
         end
         FUNC_READ_BYTE: begin
            if (c.byte_addr >= FB_BYTES)
               r.status = STATUS_REJECTED;
            else
               r.read_data = shadow_fb[c.byte_addr];
         end
         default: begin
            r.status = STATUS_REJECTED;
         end
      endcase
      return r;
   endfunction

   // Command with every field random; callers overwrite what matters
   function automatic fbtr_req_type noise_cmd();
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      return noise[$bits(fbtr_req_type)-1:0];
   endfunction

   // Cursor move, mostly in range and sometimes at or past the edges
   function automatic fbtr_req_type cursor_cmd();
      fbtr_req_type c;
      c       = noise_cmd();
      c.func  = FUNC_SET_CURSOR;
      c.pos_x = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, DISP_W));
      c.pos_y = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, DISP_H));
      return c;
   endfunction

   // Character whose glyph is fully loaded, else an unsupported code
   function automatic logic [7:0] pick_char();
      logic [7:0] code;
      logic [5:0] slot;
      int         k;
      int         tries;
      if ($urandom_range(0, 9) != 0) begin
         for (tries = 0; tries < 16; tries++) begin
            k    = $urandom_range(0, 38);
            code = (k == 0) ? CHAR_SPACE :
                   (k <= 12) ? 8'(DIGIT_BASE + k) : 8'(ALPHA_BASE + k);
            if (map_glyph(code, slot) && rows_loaded[slot] == 8'hFF)
               return code;
         end
      end
      do
         code = 8'($urandom);
      while (map_glyph(code, slot));
      return code;
   endfunction

   function automatic void note_mismatch(input string what, input fbtr_rsp_type want,
                                         input fbtr_rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s: expected status %0d data 0x%02h, got status %0d data 0x%02h",
                  $time, what, want.status, want.read_data, got.status, got.read_data);
   endfunction

   // Drive one command beat after a random gap; predict it when accepted
   task automatic send_cmd(input fbtr_req_type item, input logic typed,
                           input fbtr_rsp_type want);
      int           gap;
      fbtr_rsp_type predicted;
      if ($urandom_range(0, 31) == 0)
         req_eager = !req_eager;
      gap = req_eager ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      predicted = apply_cmd(item);
      pending_rsp_q.push_back(typed ? want : predicted);
      if (predicted.status == STATUS_REJECTED)
         rejects++;
      cmds_sent++;
      @(negedge clock);
   endtask

   task automatic add_row(input logic [2:0] func, input logic [7:0] x, input logic [7:0] y,
                          input logic colour, input logic [7:0] code, input logic [5:0] slot,
                          input logic [2:0] row, input logic [7:0] bits,
                          input logic [9:0] addr, input logic typed, input logic status,
                          input logic [7:0] data);
      dir_row_type r;
      r.cmd            = '{func, x, y, colour, code, slot, row, bits, addr};
      r.typed          = typed;
      r.want.status    = status;
      r.want.read_data = data;
      dir_rows.push_back(r);
   endtask

   // Write the column offset; only called with nothing outstanding
   task automatic write_offset(input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      col_offset = value;
      offset_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   // Random traffic: glyph loads, runs of text, and single commands
   task automatic run_phase(input int quota);
      fbtr_req_type item;
      logic [5:0]   slot;
      int           sent;
      int           pick;
      int           n;
      int           k;
      int           page;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 99);
         item = noise_cmd();
         if (pick < 15) begin
            // load a whole glyph, mostly into slots that characters map to
            slot = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(39, SLOTS - 1)) :
                                                 6'($urandom_range(0, 38));
            item.func       = FUNC_LOAD_FONT;
            item.glyph_slot = slot;
            for (k = 0; k < FONT_SIZE; k++) begin
               item.glyph_row  = 3'(k);
               item.glyph_bits = 8'($urandom);
               send_cmd(item, 1'b0, '0);
               sent++;
            end
         end else if (pick < 60) begin
            // write a run of text, sometimes moving the cursor first
            n = $urandom_range(1, 24);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_cmd(cursor_cmd(), 1'b0, '0);
                  sent++;
               end
               item           = noise_cmd();
               item.func      = FUNC_WRITE_CHAR;
               item.char_code = pick_char();
               send_cmd(item, 1'b0, '0);
               sent++;
            end
            // read back bytes of the page under the cursor
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++) begin
               page           = (cur_y > 8'd63) ? 7 : cur_y[5:3];
               item           = noise_cmd();
               item.func      = FUNC_READ_BYTE;
               item.byte_addr = 10'(page * DISP_W + $urandom_range(0, DISP_W - 1));
               send_cmd(item, 1'b0, '0);
               sent++;
            end
         end else if (pick < 75) begin
            // draw a pixel, then often read its byte back
            item.func  = FUNC_PIXEL;
            item.pos_x = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                                                       8'($urandom_range(0, DISP_W - 1));
            item.pos_y = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                                                       8'($urandom_range(0, DISP_H - 1));
            send_cmd(item, 1'b0, '0);
            sent++;
            if (item.pos_x < DISP_W && item.pos_y < DISP_H && $urandom_range(0, 1) == 1) begin
               item.func      = FUNC_READ_BYTE;
               item.byte_addr = 10'(item.pos_y[7:3] * DISP_W + item.pos_x);
               send_cmd(item, 1'b0, '0);
               sent++;
            end
         end else if (pick < 87) begin
            item.func = FUNC_READ_BYTE;
            send_cmd(item, 1'b0, '0);
            sent++;
         end else if (pick < 92) begin
            send_cmd(cursor_cmd(), 1'b0, '0);
            sent++;
         end else if (pick < 95) begin
            item.func = FUNC_LOAD_FONT;
            send_cmd(item, 1'b0, '0);
            sent++;
         end else if (pick < 98) begin
            item.func = ($urandom_range(0, 1) == 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
            send_cmd(item, 1'b0, '0);
            sent++;
         end else begin
            item.func = FUNC_FILL;
            send_cmd(item, 1'b0, '0);
            sent++;
         end
      end
   endtask

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   framebuffer_text_renderer_top #(
      .DISPLAY_WIDTH  (DISP_W),
      .DISPLAY_HEIGHT (DISP_H),
      .GLYPH_SLOTS    (SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Abort when no beat moves on any channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no beat for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, pending_rsp_q.size());
         $display("framebuffer_text_renderer_top_tb: FAIL");
         $finish;
      end
   end

   // Take result beats with random stalls and check each against the oldest prediction
   initial begin : rsp_side
      int           hold;
      fbtr_rsp_type want;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0)
            rsp_eager = !rsp_eager;
         hold = rsp_eager ? 0 : $urandom_range(0, 9);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do
            @(posedge clock);
         while (rsp_valid !== 1'b1);
         results_checked++;
         if (pending_rsp_q.size() == 0) begin
            note_mismatch("result with nothing outstanding", '0, rsp_data);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.status !== want.status || rsp_data.read_data !== want.read_data)
               note_mismatch("result mismatch", want, rsp_data);
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int         p;
      logic [3:0] offset;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      reset     = 1'b1;

      // shadow state after reset
      foreach (shadow_fb[i])
         shadow_fb[i] = 8'h00;
      foreach (shadow_font[i])
         shadow_font[i] = 8'h00;
      foreach (rows_loaded[i])
         rows_loaded[i] = 8'h00;
      cur_x      = CURSOR_X_RESET;
      cur_y      = 8'd0;
      text_row   = 4'd0;
      col_offset = OFFSET_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows: func x y colour char slot row bits addr | typed status data
      add_row(FUNC_READ_BYTE,  0,   0,   0, 0,   0, 0, 0,     0,    1, STATUS_DONE, 8'h00);
      add_row(FUNC_PIXEL,      127, 63,  1, 0,   0, 0, 0,     0,    1, STATUS_DONE, 8'h00);
      add_row(FUNC_READ_BYTE,  0,   0,   0, 0,   0, 0, 0,     1023, 1, STATUS_DONE, 8'h80);
      add_row(FUNC_PIXEL,      128, 0,   1, 0,   0, 0, 0,     0,    1, STATUS_REJECTED, 8'h00);
      add_row(FUNC_PIXEL,      0,   64,  1, 0,   0, 0, 0,     0,    1, STATUS_REJECTED, 8'h00);
      add_row(FUNC_SPARE_A,    0,   0,   0, 0,   0, 0, 0,     0,    1, STATUS_REJECTED, 8'h00);
      add_row(FUNC_SPARE_B,    255, 255, 1, 255, 63, 7, 255, 1023, 1, STATUS_REJECTED, 8'h00);
      add_row(FUNC_SET_CURSOR, 129, 0,   0, 0,   0, 0, 0,     0,    1, STATUS_REJECTED, 8'h00);
      add_row(FUNC_SET_CURSOR, 0,   65,  0, 0,   0, 0, 0,     0,    1, STATUS_REJECTED, 8'h00);
      add_row(FUNC_FILL,       0,   0,   1, 0,   0, 0, 0,     0,    1, STATUS_DONE, 8'h00);
      add_row(FUNC_READ_BYTE,  0,   0,   0, 0,   0, 0, 0,     512,  1, STATUS_DONE, 8'hFF);
      add_row(FUNC_FILL,       0,   0,   0, 0,   0, 0, 0,     0,    1, STATUS_DONE, 8'h00);
      add_row(FUNC_WRITE_CHAR, 0,   0,   1, 255, 0, 0, 0,     0,    1, STATUS_REJECTED, 8'h00);
      add_row(FUNC_LOAD_FONT,  0,   0,   0, 0,   0, 0, 8'hFF, 0,    0, STATUS_DONE, 8'h00);
      add_row(FUNC_LOAD_FONT,  0,   0,   0, 0,   0, 1, 8'h81, 0,    0, STATUS_DONE, 8'h00);
      add_row(FUNC_LOAD_FONT,  0,   0,   0, 0,   0, 2, 8'h00, 0,    0, STATUS_DONE, 8'h00);
      add_row(FUNC_LOAD_FONT,  0,   0,   0, 0,   0, 3, 8'hA5, 0,    0, STATUS_DONE, 8'h00);
      add_row(FUNC_LOAD_FONT,  0,   0,   0, 0,   0, 4, 8'h5A, 0,    0, STATUS_DONE, 8'h00);
      add_row(FUNC_LOAD_FONT,  0,   0,   0, 0,   0, 5, 8'h3C, 0,    0, STATUS_DONE, 8'h00);
      add_row(FUNC_LOAD_FONT,  0,   0,   0, 0,   0, 6, 8'hC3, 0,    0, STATUS_DONE, 8'h00);
      add_row(FUNC_LOAD_FONT,  0,   0,   0, 0,   0, 7, 8'h7E, 0,    0, STATUS_DONE, 8'h00);
      // glyph clipped at the bottom right corner, then a line wrap
      add_row(FUNC_SET_CURSOR, 124, 60,  0, 0,   0, 0, 0,     0,    0, STATUS_DONE, 8'h00);
      add_row(FUNC_WRITE_CHAR, 0,   0,   1, 32,  0, 0, 0,     0,    0, STATUS_DONE, 8'h00);
      add_row(FUNC_READ_BYTE,  0,   0,   0, 0,   0, 0, 0,     1023, 0, STATUS_DONE, 8'h00);
      add_row(FUNC_WRITE_CHAR, 0,   0,   0, 32,  0, 0, 0,     0,    0, STATUS_DONE, 8'h00);
      foreach (dir_rows[i])
         send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

      // random phases, each under a new column offset
      for (p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         drain();
         offset = (p == 0) ? 4'd0 : (p == 1) ? 4'd15 : 4'($urandom_range(0, 15));
         write_offset(offset);
         run_phase(PHASE_ITEMS);
      end
      req_valid <= 1'b0;
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Ran %0d commands (%0d rejected) over %0d column offsets; %0d results checked.",
               cmds_sent, rejects, offset_writes + 1, results_checked);
      $display("Text: %0d glyphs drawn, %0d line wraps, %0d page wraps; %0d mismatches.",
               chars_drawn, line_wraps, page_wraps, mismatches);
      if (mismatches == 0 && pending_rsp_q.size() == 0)
         $display("framebuffer_text_renderer_top_tb: PASS");
      else
         $display("framebuffer_text_renderer_top_tb: FAIL");
      $finish;
   end

endmodule
